// ===== hdl/gle_pkg.sv =====
// Package for the GIF LZW encoder: item types, dictionary entry layout,
// controller states and command/status bundles.
// No dependencies; every other file of the block imports it.
package gle_pkg;

    localparam int KEY_W     = 20;
    localparam int CODE_W    = 12;
    localparam int NFC_W     = 13;
    localparam int WIDTH_W   = 4;
    localparam int EPOCH_W   = 8;
    localparam int ACC_W     = 24;
    localparam int FILL_W    = 5;

    localparam logic [WIDTH_W-1:0] WIDTH_CAP = 4'd12;
    localparam logic [3:0]         MCS_RESET = 4'd8;
    localparam logic [3:0]         MCS_MIN   = 4'd2;
    localparam logic [3:0]         MCS_MAX   = 4'd8;
    localparam logic [31:0]        HASH_MULT = 32'h9E3779B1;

    typedef struct packed {
        logic [7:0] pixel;
        logic       first_pixel;
        logic       last_pixel;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       block_end;
        logic [7:0] block_len;
        logic       frame_done;
    } byte_item_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  code;
    } dict_entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_EMIT_CLR0,
        S_HASH,
        S_READ,
        S_CMP,
        S_EMIT_PFX,
        S_EMIT_FCLR,
        S_TAIL,
        S_EMIT_LPFX,
        S_EMIT_END,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_CLEAR,
        SEL_PREFIX,
        SEL_END
    } code_sel_t;

    typedef struct packed {
        logic      latch;
        logic      restart;
        logic      prefix_pix;
        logic      prefix_hit;
        logic      load_hash;
        logic      addr_inc;
        logic      insert;
        logic      clr_step;
        code_sel_t code_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic probe_empty;
        logic probe_hit;
        logic dict_full;
        logic clr_pending;
        logic clr_last;
        logic last;
    } dp_sts_t;

    typedef struct packed {
        logic emit;
        logic fresh;
        logic last_code;
    } pk_cmd_t;

endpackage

// ===== hdl/gle_packer.sv =====
// Bit packer: appends codes LSB first and, with the output free, drains one byte per
// cycle to an output register, tagging sub-block and frame ends. Depends on gle_pkg.
module gle_packer
    import gle_pkg::*;
#(
    parameter int SUB_BLOCK_BYTES = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pk_cmd_t            cmd,
    input  logic [CODE_W-1:0]  code,
    input  logic [WIDTH_W-1:0] width,
    output logic               ready,
    output logic               byte_valid,
    input  logic               byte_ready,
    output byte_item_t         byte_item
);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              last_reg, last_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic              obv_reg, obv_next;
    byte_item_t        item_reg, item_next;

    logic              slot_free;
    logic              drain;
    logic [CODE_W-1:0] masked;
    logic [ACC_W-1:0]  acc_base;
    logic [FILL_W-1:0] fill_base;
    logic [FILL_W-1:0] fill_left;
    logic              is_last;
    logic [7:0]        cnt_inc;
    logic              closes;

    assign slot_free = !obv_reg || byte_ready;
    assign ready     = (fill_reg < FILL_W'(8)) && !last_reg;
    assign drain     = ((fill_reg >= FILL_W'(8)) || (last_reg && fill_reg != '0)) && slot_free;

    always_comb
    begin
        // A width of 12 makes the shifted one wrap to zero, so the mask is all ones.
        masked    = code & ((CODE_W'(1) << width) - CODE_W'(1));
        acc_base  = cmd.fresh ? '0 : acc_reg;
        fill_base = cmd.fresh ? '0 : fill_reg;
        fill_left = (fill_reg >= FILL_W'(8)) ? fill_reg - FILL_W'(8) : '0;
        is_last   = last_reg && (fill_left == '0);
        cnt_inc   = cnt_reg + 8'd1;
        closes    = (cnt_inc >= 8'(SUB_BLOCK_BYTES)) || is_last;

        acc_next  = acc_reg;
        fill_next = fill_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        obv_next  = obv_reg;
        item_next = item_reg;

        if (cmd.emit)
        begin
            acc_next  = acc_base | (ACC_W'(masked) << fill_base);
            fill_next = fill_base + FILL_W'(width);
            last_next = cmd.last_code;
            if (cmd.fresh)
            begin
                cnt_next = '0;
            end
        end
        else if (drain)
        begin
            obv_next             = 1'b1;
            item_next.out_byte   = acc_reg[7:0];
            item_next.block_end  = closes;
            item_next.block_len  = cnt_inc;
            item_next.frame_done = is_last;
            cnt_next             = closes ? '0 : cnt_inc;
            acc_next             = is_last ? '0 : (acc_reg >> 8);
            fill_next            = fill_left;
            if (is_last)
            begin
                last_next = 1'b0;
            end
        end

        if (!drain && byte_ready)
        begin
            obv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            fill_reg <= '0;
            last_reg <= 1'b0;
            cnt_reg  <= '0;
            obv_reg  <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
            last_reg <= last_next;
            cnt_reg  <= cnt_next;
            obv_reg  <= obv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign byte_valid = obv_reg;
    assign byte_item  = item_reg;

endmodule

// ===== hdl/gle_datapath.sv =====
// Datapath: configuration register, prefix and code counters, hash unit and
// the dictionary memory with epoch tags. Depends on gle_pkg.
module gle_datapath
    import gle_pkg::*;
#(
    parameter int HASH_DEPTH = 8192,
    parameter int CODE_LIMIT = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  pix_item_t          pix_item,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    output logic [CODE_W-1:0]  code,
    output logic [WIDTH_W-1:0] code_width
);

    localparam int HB = $clog2(HASH_DEPTH);

    dict_entry_t mem [HASH_DEPTH];

    logic [3:0]         mcs_reg;
    logic [7:0]         pix_reg;
    logic               last_reg;
    logic [CODE_W-1:0]  prefix_reg;
    logic [NFC_W-1:0]   nfc_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [HB-1:0]      addr_reg;
    logic [HB-1:0]      clr_addr_reg;
    logic               clr_pending_reg;
    dict_entry_t        rdata_reg;

    logic [CODE_W-1:0]  clr_code;
    logic [KEY_W-1:0]   key;
    logic [HB-1:0]      key_lo;
    logic [HB-1:0]      hash_mul;
    logic [HB-1:0]      hash;
    logic [NFC_W-1:0]   nfc_inc;
    logic               entry_valid;
    logic               mem_we;
    logic [HB-1:0]      mem_waddr;
    dict_entry_t        mem_wdata;

    assign clr_code   = CODE_W'(1) << mcs_reg;
    assign key        = {prefix_reg, pix_reg};
    assign key_lo     = key[HB-1:0];
    assign hash_mul   = HASH_MULT[HB-1:0];
    // Only the low bits of the product matter for a power-of-two table.
    assign hash       = key_lo * hash_mul;
    assign nfc_inc    = nfc_reg + NFC_W'(1);

    assign entry_valid     = rdata_reg.epoch == epoch_reg;
    assign sts.probe_empty = !entry_valid;
    assign sts.probe_hit   = entry_valid && (rdata_reg.key == key);
    assign sts.dict_full   = nfc_reg >= NFC_W'(CODE_LIMIT);
    assign sts.clr_pending = clr_pending_reg;
    assign sts.clr_last    = clr_addr_reg == '1;
    assign sts.last        = last_reg;

    assign code_width = width_reg;

    always_comb
    begin
        case (cmd.code_sel)
            SEL_CLEAR:  code = clr_code;
            SEL_PREFIX: code = prefix_reg;
            SEL_END:    code = clr_code + CODE_W'(1);
            default:    code = clr_code;
        endcase
    end

    always_comb
    begin
        mem_we    = cmd.insert || cmd.clr_step;
        mem_waddr = cmd.clr_step ? clr_addr_reg : addr_reg;
        mem_wdata = cmd.clr_step ? dict_entry_t'('0)
                                 : {epoch_reg, key, nfc_reg[CODE_W-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcs_reg         <= MCS_RESET;
            pix_reg         <= '0;
            last_reg        <= 1'b0;
            prefix_reg      <= '0;
            nfc_reg         <= NFC_W'(258);
            width_reg       <= WIDTH_W'(9);
            epoch_reg       <= EPOCH_W'(1);
            addr_reg        <= '0;
            clr_addr_reg    <= '0;
            clr_pending_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_wdata < MCS_MIN)
                begin
                    mcs_reg <= MCS_MIN;
                end
                else if (cfg_wdata > MCS_MAX)
                begin
                    mcs_reg <= MCS_MAX;
                end
                else
                begin
                    mcs_reg <= cfg_wdata;
                end
            end
            if (cmd.latch)
            begin
                pix_reg  <= pix_item.pixel;
                last_reg <= pix_item.last_pixel;
            end
            if (cmd.load_hash)
            begin
                addr_reg <= hash;
            end
            else if (cmd.addr_inc)
            begin
                addr_reg <= addr_reg + HB'(1);
            end
            if (cmd.prefix_hit)
            begin
                prefix_reg <= rdata_reg.code;
            end
            else if (cmd.prefix_pix)
            begin
                prefix_reg <= CODE_W'(pix_reg);
            end
            if (cmd.restart)
            begin
                nfc_reg   <= NFC_W'(clr_code) + NFC_W'(2);
                width_reg <= mcs_reg + WIDTH_W'(1);
                // Entries of older epochs read as empty; a wrap needs a real sweep.
                if (epoch_reg == '1)
                begin
                    epoch_reg       <= EPOCH_W'(1);
                    clr_pending_reg <= 1'b1;
                end
                else
                begin
                    epoch_reg <= epoch_reg + EPOCH_W'(1);
                end
            end
            else if (cmd.insert)
            begin
                nfc_reg <= nfc_inc;
                if ((nfc_inc > (NFC_W'(1) << width_reg)) && (width_reg < WIDTH_CAP))
                begin
                    width_reg <= width_reg + WIDTH_W'(1);
                end
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + HB'(1);
                if (clr_addr_reg == '1)
                begin
                    clr_pending_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== hdl/gle_ctrl.sv =====
// Controller state machine: sequences input acceptance, dictionary probes,
// code emission and the clearing sweep. Depends on gle_pkg.
module gle_ctrl
    import gle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pix_valid,
    input  logic    first_in,
    output logic    pix_ready,
    input  dp_sts_t sts,
    input  logic    pk_ready,
    output dp_cmd_t cmd,
    output pk_cmd_t pk_cmd
);

    ctrl_state_t state_reg, state_next;
    logic        in_frame_reg, in_frame_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_frame_reg <= in_frame_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_frame_next = in_frame_reg;
        pix_ready     = 1'b0;
        cmd           = '0;
        cmd.code_sel  = SEL_PREFIX;
        pk_cmd        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                pix_ready = 1'b1;
                if (pix_valid)
                begin
                    cmd.latch = 1'b1;
                    if (first_in || !in_frame_reg)
                    begin
                        in_frame_next = 1'b1;
                        state_next    = S_START;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_START:
            begin
                cmd.restart    = 1'b1;
                cmd.prefix_pix = 1'b1;
                state_next     = S_EMIT_CLR0;
            end
            S_EMIT_CLR0:
            begin
                cmd.code_sel = SEL_CLEAR;
                if (pk_ready)
                begin
                    pk_cmd.emit  = 1'b1;
                    pk_cmd.fresh = 1'b1;
                    state_next   = S_TAIL;
                end
            end
            S_HASH:
            begin
                cmd.load_hash = 1'b1;
                state_next    = S_READ;
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sts.probe_hit)
                begin
                    cmd.prefix_hit = 1'b1;
                    state_next     = S_TAIL;
                end
                else if (sts.probe_empty)
                begin
                    state_next = S_EMIT_PFX;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_EMIT_PFX:
            begin
                cmd.code_sel = SEL_PREFIX;
                if (pk_ready)
                begin
                    pk_cmd.emit = 1'b1;
                    if (sts.dict_full)
                    begin
                        state_next = S_EMIT_FCLR;
                    end
                    else
                    begin
                        // The address register still points at the empty slot.
                        cmd.insert     = 1'b1;
                        cmd.prefix_pix = 1'b1;
                        state_next     = S_TAIL;
                    end
                end
            end
            S_EMIT_FCLR:
            begin
                cmd.code_sel = SEL_CLEAR;
                if (pk_ready)
                begin
                    pk_cmd.emit    = 1'b1;
                    cmd.restart    = 1'b1;
                    cmd.prefix_pix = 1'b1;
                    state_next     = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = sts.last ? S_EMIT_LPFX : S_DONE;
            end
            S_EMIT_LPFX:
            begin
                cmd.code_sel = SEL_PREFIX;
                if (pk_ready)
                begin
                    pk_cmd.emit = 1'b1;
                    state_next  = S_EMIT_END;
                end
            end
            S_EMIT_END:
            begin
                cmd.code_sel = SEL_END;
                if (pk_ready)
                begin
                    pk_cmd.emit      = 1'b1;
                    pk_cmd.last_code = 1'b1;
                    in_frame_next    = 1'b0;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = sts.clr_pending ? S_CLEAR : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/gif_lzw_encoder.sv =====
// Channel   Signals                                 Payload
// config    cfg_we, cfg_wdata                       root code width (4 bits)
// pixels    pix_valid, pix_ready, pix_item          pixel, first_pixel, last_pixel
// bytes     byte_valid, byte_ready, byte_item       out_byte, block_end, block_len, frame_done
//
// A pixel inside a frame is accepted, then hashed, read and compared, with one more read and
// compare per extra probe; a first pixel takes a restart step instead of the probe.
// Each code is then emitted once the packer holds under eight bits, and the tail and done
// states close the item; bytes leave the packer at most one per cycle.
// After reset, and after every 255th dictionary restart, a clearing sweep over all HASH_DEPTH
// entries runs first. A stalled byte output holds the packer and so the controller.
// Top level of the GIF LZW encoder; depends on gle_pkg and the three submodules.
module gif_lzw_encoder
    import gle_pkg::*;
#(
    parameter int HASH_DEPTH      = 8192,
    parameter int CODE_LIMIT      = 4096,
    parameter int SUB_BLOCK_BYTES = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic       pix_valid,
    output logic       pix_ready,
    input  pix_item_t  pix_item,
    output logic       byte_valid,
    input  logic       byte_ready,
    output byte_item_t byte_item
);

    dp_cmd_t            dp_cmd;
    dp_sts_t            dp_sts;
    pk_cmd_t            pk_cmd;
    logic               pk_ready;
    logic [CODE_W-1:0]  code;
    logic [WIDTH_W-1:0] code_width;

    gle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .first_in  (pix_item.first_pixel),
        .pix_ready (pix_ready),
        .sts       (dp_sts),
        .pk_ready  (pk_ready),
        .cmd       (dp_cmd),
        .pk_cmd    (pk_cmd)
    );

    gle_datapath #(
        .HASH_DEPTH (HASH_DEPTH),
        .CODE_LIMIT (CODE_LIMIT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .pix_item   (pix_item),
        .cmd        (dp_cmd),
        .sts        (dp_sts),
        .code       (code),
        .code_width (code_width)
    );

    gle_packer #(
        .SUB_BLOCK_BYTES (SUB_BLOCK_BYTES)
    ) u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (pk_cmd),
        .code       (code),
        .width      (code_width),
        .ready      (pk_ready),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item)
    );

    // No pixel may enter while the dictionary sweep is still owed.
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        dp_sts.clr_pending |-> !pix_ready)
        else $error("pixel accepted with dictionary sweep pending");

    a_emit_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pk_cmd.emit |-> pk_ready)
        else $error("code emitted while packer busy");

    a_frame_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_item.frame_done) |-> byte_item.block_end)
        else $error("frame end byte does not close its sub-block");

    a_block_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid |-> (byte_item.block_len != 8'd0))
        else $error("byte with zero sub-block length");

endmodule

// ===== dv/tb_gif_lzw_encoder.sv =====
// Self-checking testbench for gif_lzw_encoder: drives pixel items, predicts the packed
// LZW byte stream in a scoreboard class and compares every byte item field by field.
// Depends on gle_pkg and the encoder RTL only.
module tb_gif_lzw_encoder
    import gle_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    class lzw_scoreboard;
        int unsigned mcs;
        bit [11:0]   dict [int unsigned];
        int unsigned prefix, free_code, width, acc, fill, blk;
        bit          open;
        byte_item_t  bytes_q [$];
        byte_item_t  batch [$];
        int          errors;

        function new();
            mcs = 32'(MCS_RESET);
            restart();
            prefix = 0; acc = 0; fill = 0; blk = 0; open = 0; errors = 0;
        endfunction

        task report(input string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Writes saturate into the legal range of root widths.
        function void set_mcs(input int unsigned v);
            v = v & 15;
            if (v < MCS_MIN) v = 32'(MCS_MIN);
            if (v > MCS_MAX) v = 32'(MCS_MAX);
            mcs = v;
        endfunction

        function void restart();
            dict.delete();
            free_code = (1 << mcs) + 2;
            width = mcs + 1;
        endfunction

        function void push_out(input int unsigned b);
            byte_item_t r;
            blk = (blk + 1) & 255;
            r.out_byte   = b[7:0];
            r.block_end  = (blk >= 255);
            r.block_len  = blk[7:0];
            r.frame_done = 1'b0;
            batch.push_back(r);
            if (blk >= 255) blk = 0;
        endfunction

        function void emit(input int unsigned code);
            code = code & ((1 << width) - 1);
            acc  = acc | (code << fill);
            fill = fill + width;
            while (fill >= 8)
            begin
                push_out(acc & 255);
                acc  = acc >> 8;
                fill = fill - 8;
            end
            acc = acc & 24'hffffff;
        endfunction

        function void note_pixel(input pix_item_t p);
            int unsigned key;
            int unsigned clr;
            batch.delete();
            clr = 1 << mcs;
            if (p.first_pixel || !open)
            begin
                acc = 0; fill = 0; blk = 0;
                restart();
                emit(1 << mcs);
                prefix = 32'(p.pixel);
                open = 1;
            end
            else
            begin
                key = (prefix << 8) | p.pixel;
                if (dict.exists(key))
                    prefix = 32'(dict[key]);
                else
                begin
                    emit(prefix);
                    if (free_code < 4096)
                    begin
                        dict[key] = free_code[11:0];
                        free_code++;
                        if (free_code > (1 << width) && width < WIDTH_CAP)
                            width++;
                    end
                    else
                    begin
                        // Code space exhausted: clear code at the old width, then restart.
                        emit(1 << mcs);
                        restart();
                    end
                    prefix = 32'(p.pixel);
                end
            end
            if (p.last_pixel)
            begin
                clr = 1 << mcs;
                emit(prefix);
                emit(clr + 1);
                if (fill > 0) push_out(acc & 255);
                acc = 0; fill = 0;
                if (batch.size() > 0)
                begin
                    batch[batch.size()-1].block_end  = 1'b1;
                    batch[batch.size()-1].frame_done = 1'b1;
                end
                blk = 0;
                open = 0;
            end
            foreach (batch[i]) bytes_q.push_back(batch[i]);
        endfunction

        function int pending();
            return bytes_q.size();
        endfunction

        task check_byte(input byte_item_t got);
            byte_item_t want;
            if (bytes_q.size() == 0)
            begin
                report($sformatf("unexpected byte item %h", got));
                return;
            end
            want = bytes_q.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
            if (got.block_end !== want.block_end)
                report($sformatf("block_end %b, expected %b", got.block_end, want.block_end));
            if (got.block_len !== want.block_len)
                report($sformatf("block_len %0d, expected %0d", got.block_len, want.block_len));
            if (got.frame_done !== want.frame_done)
                report($sformatf("frame_done %b, expected %b", got.frame_done,
                                 want.frame_done));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_wdata;
    logic       pix_valid;
    logic       pix_ready;
    pix_item_t  pix_item;
    logic       byte_valid;
    logic       byte_ready;
    byte_item_t byte_item;

    lzw_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    gif_lzw_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix_item   (pix_item),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Generous limit: clearing sweeps plus several hundred items under heavy stalls.
    initial
    begin
        #20000000;
        $display("tb_gif_lzw_encoder failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && pix_ready) sb.note_pixel(pix_item);
            if (byte_valid && byte_ready) sb.check_byte(byte_item);
        end
    end

    // Receiver: random stalls, or a long hold-off counted down here.
    initial
    begin
        @(negedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                byte_ready <= 0;
                hold_cycles = hold_cycles - 1;
            end
            else
                byte_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            @(negedge clk);
        end
    end

    task set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
    endtask

    task send_pixel(input logic [7:0] pix, input logic first, input logic last);
        pix_item_t p;
        p.pixel = pix; p.first_pixel = first; p.last_pixel = last;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_valid <= 0;
            @(negedge clk);
        end
        pix_valid <= 1;
        pix_item  <= p;
        @(posedge clk);
        while (!pix_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Wait until every expected byte has come, then let a hit pixel finish its probes.
    task drain();
        pix_valid <= 0;
        @(negedge clk);
        while (sb.pending() > 0) @(negedge clk);
        repeat (64) @(negedge clk);
    endtask

    task write_mcs(input logic [3:0] v);
        cfg_we    <= 1;
        cfg_wdata <= v;
        sb.set_mcs(32'(v));
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // Frames of random length; a small alphabet makes dictionary hits common.
    // With noise, the first/last marks are scrambled now and then.
    task send_frames(input int n, input int noise_pct);
        int len, alpha;
        logic [7:0] pix;
        logic f, l;
        while (n > 0)
        begin
            len = $urandom_range(1, 40);
            if (len > n) len = n;
            alpha = (1 << $urandom_range(1, sb.mcs)) - 1;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 99) < 5) pix = 8'($urandom_range(0, 255));
                else pix = 8'($urandom_range(0, alpha));
                f = (i == 0);
                l = (i == len - 1);
                if ($urandom_range(0, 99) < noise_pct)
                begin
                    f = 1'($urandom_range(0, 1));
                    l = 1'($urandom_range(0, 1));
                end
                send_pixel(pix, f, l);
            end
            n = n - len;
        end
    endtask

    initial
    begin
        logic [3:0] mcs_vals [8];
        mcs_vals = '{4'd15, 4'd3, 4'd5, 4'd8, 4'd2, 4'd7, 4'd4, 4'd6};
        sb = new();
        rst_n = 0; cfg_we = 0; cfg_wdata = 0; pix_valid = 0; pix_item = '0;
        byte_ready = 0; hold_cycles = 0;
        set_idling(0);
        repeat (4) @(negedge clk);
        rst_n = 1;

        // Directed: one-pixel frame, extreme pixels, a hit, a pixel outside a frame
        // and a new frame started inside an open one.
        send_pixel(8'd0, 1, 1);
        send_pixel(8'd255, 1, 0);
        send_pixel(8'd255, 0, 0);
        send_pixel(8'd255, 0, 0);
        send_pixel(8'd255, 0, 1);
        send_pixel(8'd7, 0, 0);
        send_pixel(8'd7, 0, 0);
        send_pixel(8'd3, 1, 0);
        send_pixel(8'd3, 0, 0);
        send_pixel(8'd3, 0, 0);
        send_pixel(8'd3, 0, 1);
        drain();
        // Root width below the legal range saturates; out-of-range pixels get masked.
        write_mcs(4'd0);
        send_pixel(8'd200, 1, 0);
        send_pixel(8'd1, 0, 0);
        send_pixel(8'd200, 0, 0);
        send_pixel(8'd1, 0, 1);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_mcs(mcs_vals[ph]);
            set_idling(ph % 4);
            // The receiver holds off long enough for the encoder to stall its input.
            if (ph == 1) hold_cycles = 400;
            send_frames(58, (ph % 2 == 1) ? 10 : 2);
            drain();
        end

        repeat (100) @(negedge clk);
        if (sb.errors == 0)
            $display("tb_gif_lzw_encoder passed");
        else
            $display("tb_gif_lzw_encoder failed");
        $finish;
    end
endmodule
